### rtl/speq_pkg.sv
// Shared types and constants for the sorted priority event queue.
// No dependencies; used by every module of the block except speq_ram.
`timescale 1ns / 1ps

package speq_pkg;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    typedef struct packed {
        logic        [7:0]  pri;
        logic        [3:0]  code;
        logic signed [15:0] amt;
        logic        [7:0]  sys;
        logic        [7:0]  res;
    } t_entry;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PUSH_CHK,
        S_PUSH_CMP,
        S_POP_OUT
    } t_state;

    typedef enum logic [1:0] {
        RD_HEAD,
        RD_KM1,
        RD_KM2
    } t_rd_sel;

    typedef struct packed {
        logic    capture;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    shift_wr;
        logic    ins_wr;
        logic    pop_done;
        logic    res_load;
    } t_dp_cmd;

    typedef struct packed {
        logic full;
        logic empty;
        logic k_zero;
        logic k_one;
        logic greater;
    } t_dp_sts;

endpackage

### rtl/speq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module speq_ram #(
    parameter int WIDTH = 44,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/speq_ctrl.sv
// Controller state machine of the sorted priority event queue.
// Depends on speq_pkg; drives the datapath command struct.
`timescale 1ns / 1ps

module speq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_command,
    input  speq_pkg::t_dp_sts i_sts,
    output speq_pkg::t_dp_cmd o_cmd,
    output logic              o_busy
);

    speq_pkg::t_state r_state;
    speq_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= speq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            speq_pkg::S_IDLE: begin
                if (i_start) begin
                    if (i_command == speq_pkg::CMD_PUSH) begin
                        if (!i_sts.full) begin
                            n_state = speq_pkg::S_PUSH_CHK;
                        end
                    end else if (!i_sts.empty) begin
                        n_state = speq_pkg::S_POP_OUT;
                    end
                end
            end
            speq_pkg::S_PUSH_CHK: begin
                if (i_sts.k_zero) begin
                    n_state = speq_pkg::S_IDLE;
                end else begin
                    n_state = speq_pkg::S_PUSH_CMP;
                end
            end
            speq_pkg::S_PUSH_CMP: begin
                if (i_sts.greater) begin
                    n_state = speq_pkg::S_IDLE;
                end else if (i_sts.k_one) begin
                    n_state = speq_pkg::S_PUSH_CHK;
                end
            end
            speq_pkg::S_POP_OUT: begin
                n_state = speq_pkg::S_IDLE;
            end
            default: begin
                n_state = speq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.rd_sel = speq_pkg::RD_HEAD;
        unique case (r_state)
            speq_pkg::S_IDLE: begin
                if (i_start) begin
                    if (i_command == speq_pkg::CMD_PUSH) begin
                        if (i_sts.full) begin
                            o_cmd.res_load = 1'b1;
                        end else begin
                            o_cmd.capture = 1'b1;
                        end
                    end else if (i_sts.empty) begin
                        o_cmd.res_load = 1'b1;
                    end else begin
                        o_cmd.rd_en  = 1'b1;
                        o_cmd.rd_sel = speq_pkg::RD_HEAD;
                    end
                end
            end
            speq_pkg::S_PUSH_CHK: begin
                if (i_sts.k_zero) begin
                    o_cmd.ins_wr   = 1'b1;
                    o_cmd.res_load = 1'b1;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = speq_pkg::RD_KM1;
                end
            end
            speq_pkg::S_PUSH_CMP: begin
                if (i_sts.greater) begin
                    o_cmd.ins_wr   = 1'b1;
                    o_cmd.res_load = 1'b1;
                end else begin
                    o_cmd.shift_wr = 1'b1;
                    if (!i_sts.k_one) begin
                        o_cmd.rd_en  = 1'b1;
                        o_cmd.rd_sel = speq_pkg::RD_KM2;
                    end
                end
            end
            speq_pkg::S_POP_OUT: begin
                o_cmd.pop_done = 1'b1;
                o_cmd.res_load = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    assign o_busy = (r_state != speq_pkg::S_IDLE);

endmodule

### rtl/speq_dp.sv
// Datapath: circular entry store in RAM, head and count, insertion walk, result registers.
// Depends on speq_pkg and speq_ram.
`timescale 1ns / 1ps

module speq_dp #(
    parameter int DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  speq_pkg::t_dp_cmd  i_cmd,
    output speq_pkg::t_dp_sts  o_sts,
    input  logic [7:0]         i_priority_req,
    input  logic [3:0]         i_status_code,
    input  logic signed [15:0] i_amount,
    input  logic [7:0]         i_system_handle,
    input  logic [7:0]         i_resource_handle,
    output logic               o_done,
    output logic               o_ok,
    output speq_pkg::t_entry   o_ent,
    output logic [4:0]         o_occupancy
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = $bits(speq_pkg::t_entry);

    logic [AW-1:0]    r_head;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic [CW-1:0]    r_k;
    speq_pkg::t_entry r_item;
    logic             r_done;
    logic             r_ok;
    speq_pkg::t_entry r_res;
    logic [4:0]       r_occ;

    speq_pkg::t_entry rd_ent;
    logic [EW-1:0]    rd_data;
    logic [AW-1:0]    rd_addr;
    logic [AW-1:0]    wr_addr;
    speq_pkg::t_entry wr_ent;
    logic             wr_en;
    logic [31:0]      cnt_ext;

    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] head,
                                              input logic [CW-1:0] lpos);
        logic [CW:0] s;
        s = (CW + 1)'(head) + {1'b0, lpos};
        if (s >= (CW + 1)'(DEPTH)) begin
            s = s - (CW + 1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    assign rd_ent  = speq_pkg::t_entry'(rd_data);
    assign wr_en   = i_cmd.shift_wr | i_cmd.ins_wr;
    assign wr_addr = f_phys(r_head, r_k);
    assign wr_ent  = i_cmd.shift_wr ? rd_ent : r_item;

    always_comb begin
        unique case (i_cmd.rd_sel)
            speq_pkg::RD_HEAD: rd_addr = r_head;
            speq_pkg::RD_KM1:  rd_addr = f_phys(r_head, r_k - CW'(1));
            speq_pkg::RD_KM2:  rd_addr = f_phys(r_head, r_k - CW'(2));
            default:           rd_addr = r_head;
        endcase
    end

    speq_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (EW'(wr_ent)),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_count = r_count;
        if (i_cmd.ins_wr) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.pop_done) begin
            n_count = r_count - CW'(1);
        end
    end

    assign cnt_ext = 32'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= i_cmd.res_load;
            if (i_cmd.pop_done) begin
                if (r_head == AW'(DEPTH - 1)) begin
                    r_head <= '0;
                end else begin
                    r_head <= r_head + AW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item.pri  <= i_priority_req;
            r_item.code <= i_status_code;
            r_item.amt  <= i_amount;
            r_item.sys  <= i_system_handle;
            r_item.res  <= i_resource_handle;
            r_k         <= r_count;
        end else if (i_cmd.shift_wr) begin
            r_k <= r_k - CW'(1);
        end
        if (i_cmd.res_load) begin
            r_ok  <= i_cmd.ins_wr | i_cmd.pop_done;
            r_res <= i_cmd.pop_done ? rd_ent : '0;
            r_occ <= cnt_ext[4:0];
        end
    end

    assign o_sts.full    = (r_count == CW'(DEPTH));
    assign o_sts.empty   = (r_count == '0);
    assign o_sts.k_zero  = (r_k == '0);
    assign o_sts.k_one   = (r_k == CW'(1));
    assign o_sts.greater = (rd_ent.pri > r_item.pri);

    assign o_done      = r_done;
    assign o_ok        = r_ok;
    assign o_ent       = r_res;
    assign o_occupancy = r_occ;

endmodule

### rtl/sorted_priority_event_queue.sv
// Top level of the sorted priority event queue.
// Depends on speq_pkg, speq_ctrl, speq_dp (which holds speq_ram).
`timescale 1ns / 1ps

// Events are kept in a RAM-backed circular list sorted by descending priority;
// a push lands ahead of all entries of equal or lower priority. Every item
// returns exactly one result, shown for one cycle with o_done; the receiver
// cannot stall it. A new item is taken when start is high and busy is low.
// Steps per item: a rejected push (queue full) or a pop of an empty queue is
// answered from the idle state; a pop reads the head entry and returns it from
// the pop output state; a push captures the event, then its insertion walk
// moves one stored entry per cycle, through the single read and single write
// port of the entry RAM, until it finds the slot for the new event.

module sorted_priority_event_queue #(
    parameter int DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_command,
    input  logic [7:0]         i_priority_req,
    input  logic [3:0]         i_status_code,
    input  logic signed [15:0] i_amount,
    input  logic [7:0]         i_system_handle,
    input  logic [7:0]         i_resource_handle,
    output logic               o_done,
    output logic               o_ok,
    output logic [7:0]         o_out_priority,
    output logic [3:0]         o_out_status_code,
    output logic signed [15:0] o_out_amount,
    output logic [7:0]         o_out_system_handle,
    output logic [7:0]         o_out_resource_handle,
    output logic [4:0]         o_occupancy
);

    speq_pkg::t_dp_cmd cmd;
    speq_pkg::t_dp_sts sts;
    speq_pkg::t_entry  res_ent;

    speq_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_command (i_command),
        .i_sts     (sts),
        .o_cmd     (cmd),
        .o_busy    (busy)
    );

    speq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_priority_req    (i_priority_req),
        .i_status_code     (i_status_code),
        .i_amount          (i_amount),
        .i_system_handle   (i_system_handle),
        .i_resource_handle (i_resource_handle),
        .o_done            (o_done),
        .o_ok              (o_ok),
        .o_ent             (res_ent),
        .o_occupancy       (o_occupancy)
    );

    assign o_out_priority        = res_ent.pri;
    assign o_out_status_code     = res_ent.code;
    assign o_out_amount          = res_ent.amt;
    assign o_out_system_handle   = res_ent.sys;
    assign o_out_resource_handle = res_ent.res;

endmodule

### tb/sv/event_queue_checker.sv
// Checker for the sorted priority event queue: tracks the stored events,
// predicts the answer to every accepted item and compares the strobed results.
// Depends on speq_pkg for the command codes and the event record type.
`timescale 1ns / 1ps

module event_queue_checker #(
    parameter int DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic               i_command,
    input  logic [7:0]         i_priority_req,
    input  logic [3:0]         i_status_code,
    input  logic signed [15:0] i_amount,
    input  logic [7:0]         i_system_handle,
    input  logic [7:0]         i_resource_handle,
    input  logic               i_done,
    input  logic               i_ok,
    input  logic [7:0]         i_out_priority,
    input  logic [3:0]         i_out_status_code,
    input  logic signed [15:0] i_out_amount,
    input  logic [7:0]         i_out_system_handle,
    input  logic [7:0]         i_out_resource_handle,
    input  logic [4:0]         i_occupancy,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_items,
    output int                 o_results,
    output int                 o_full_rejects,
    output int                 o_empty_pops
);

    typedef struct packed {
        logic             ok;
        speq_pkg::t_entry ev;
        logic [4:0]       occ;
    } t_answer;

    speq_pkg::t_entry model_events[$];
    t_answer          owed_answers[$];
    int               fail_count   = 0;
    int               item_count   = 0;
    int               result_count = 0;
    int               full_rejects = 0;
    int               empty_pops   = 0;

    assign o_fail_count   = fail_count;
    assign o_pending      = owed_answers.size();
    assign o_items        = item_count;
    assign o_results      = result_count;
    assign o_full_rejects = full_rejects;
    assign o_empty_pops   = empty_pops;

    // newest event goes ahead of every stored event of equal or lower priority
    function automatic void apply_queue_op(input logic cmd, input speq_pkg::t_entry ev,
                                           output t_answer ans);
        int pos;
        ans = '0;
        if (cmd == speq_pkg::CMD_PUSH) begin
            if (model_events.size() < DEPTH) begin
                pos = 0;
                while (pos < model_events.size() && model_events[pos].pri > ev.pri)
                    pos++;
                model_events.insert(pos, ev);
                ans.ok = 1'b1;
            end
        end else if (model_events.size() > 0) begin
            ans.ev = model_events.pop_front();
            ans.ok = 1'b1;
        end
        ans.occ = 5'(model_events.size());
    endfunction

    function automatic void check_field(input string name, input longint want,
                                        input longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        speq_pkg::t_entry ev;
        t_answer          ans;
        t_answer          want;
        if (!i_rst_n) begin
            model_events.delete();
            owed_answers.delete();
        end else begin
            if (i_start && !i_busy) begin
                ev = '{pri: i_priority_req, code: i_status_code, amt: i_amount,
                       sys: i_system_handle, res: i_resource_handle};
                apply_queue_op(i_command, ev, ans);
                owed_answers.push_back(ans);
                item_count++;
                if (!ans.ok) begin
                    if (i_command == speq_pkg::CMD_PUSH)
                        full_rejects++;
                    else
                        empty_pops++;
                end
            end
            if (i_done) begin
                if (owed_answers.size() == 0) begin
                    $display("%0t: result with no item outstanding, expected none, %s",
                             $time, $sformatf("actual ok=%0b occ=%0d", i_ok, i_occupancy));
                    fail_count++;
                end else begin
                    want = owed_answers.pop_front();
                    result_count++;
                    check_field("ok", want.ok, i_ok);
                    check_field("out_priority", want.ev.pri, i_out_priority);
                    check_field("out_status_code", want.ev.code, i_out_status_code);
                    check_field("out_amount", want.ev.amt, i_out_amount);
                    check_field("out_system_handle", want.ev.sys, i_out_system_handle);
                    check_field("out_resource_handle", want.ev.res, i_out_resource_handle);
                    check_field("occupancy", want.occ, i_occupancy);
                end
            end
        end
    end

endmodule

### tb/sv/testbench.sv
// Top of the sorted priority event queue testbench: clock, reset, stimulus, verdict.
// Depends on speq_pkg, sorted_priority_event_queue and event_queue_checker.
`timescale 1ns / 1ps

module testbench;

    localparam int DEPTH = 16;
    localparam int N_RANDOM = 1525;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               command;
    logic [7:0]         prio_req;
    logic [3:0]         status_code;
    logic signed [15:0] amount;
    logic [7:0]         sys_handle;
    logic [7:0]         res_handle;
    logic               done;
    logic               ok;
    logic [7:0]         out_prio;
    logic [3:0]         out_status_code;
    logic signed [15:0] out_amount;
    logic [7:0]         out_sys_handle;
    logic [7:0]         out_res_handle;
    logic [4:0]         occupancy;
    int                 fail_count;
    int                 pending;
    int                 n_items;
    int                 n_results;
    int                 n_full_rejects;
    int                 n_empty_pops;
    bit                 idle_on;

    sorted_priority_event_queue #(.DEPTH(DEPTH)) i_dut (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .start                (start),
        .busy                 (busy),
        .i_command            (command),
        .i_priority_req       (prio_req),
        .i_status_code        (status_code),
        .i_amount             (amount),
        .i_system_handle      (sys_handle),
        .i_resource_handle    (res_handle),
        .o_done               (done),
        .o_ok                 (ok),
        .o_out_priority       (out_prio),
        .o_out_status_code    (out_status_code),
        .o_out_amount         (out_amount),
        .o_out_system_handle  (out_sys_handle),
        .o_out_resource_handle(out_res_handle),
        .o_occupancy          (occupancy)
    );

    event_queue_checker #(.DEPTH(DEPTH)) i_checker (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_start              (start),
        .i_busy               (busy),
        .i_command            (command),
        .i_priority_req       (prio_req),
        .i_status_code        (status_code),
        .i_amount             (amount),
        .i_system_handle      (sys_handle),
        .i_resource_handle    (res_handle),
        .i_done               (done),
        .i_ok                 (ok),
        .i_out_priority       (out_prio),
        .i_out_status_code    (out_status_code),
        .i_out_amount         (out_amount),
        .i_out_system_handle  (out_sys_handle),
        .i_out_resource_handle(out_res_handle),
        .i_occupancy          (occupancy),
        .o_fail_count         (fail_count),
        .o_pending            (pending),
        .o_items              (n_items),
        .o_results            (n_results),
        .o_full_rejects       (n_full_rejects),
        .o_empty_pops         (n_empty_pops)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("[sorted_priority_event_queue] ERROR");
        $finish;
    end

    // start idles low, payload carries junk meanwhile
    task automatic idle_gap(input int n);
        repeat (n) begin
            @(negedge clk);
            start       <= 1'b0;
            command     <= 1'($urandom);
            prio_req    <= 8'($urandom);
            status_code <= 4'($urandom);
            amount      <= 16'($urandom);
            sys_handle  <= 8'($urandom);
            res_handle  <= 8'($urandom);
            @(posedge clk);
        end
    endtask

    // busy is stable at the falling edge, so the item is taken at the next rising edge
    task automatic send_item(input logic cmd, input logic [7:0] pri, input logic [3:0] code,
                             input logic [15:0] amt, input logic [7:0] sys,
                             input logic [7:0] res);
        while (idle_on && $urandom_range(0, 99) < 29)
            idle_gap(1);
        @(negedge clk);
        start       <= 1'b1;
        command     <= cmd;
        prio_req    <= pri;
        status_code <= code;
        amount      <= amt;
        sys_handle  <= sys;
        res_handle  <= res;
        while (busy)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic send_push(input logic [7:0] pri, input logic [3:0] code,
                             input logic [15:0] amt, input logic [7:0] sys,
                             input logic [7:0] res);
        send_item(speq_pkg::CMD_PUSH, pri, code, amt, sys, res);
    endtask

    task automatic send_pop();
        send_item(speq_pkg::CMD_POP, 8'($urandom), 4'($urandom), 16'($urandom),
                  8'($urandom), 8'($urandom));
    endtask

    initial begin
        int          push_pct;
        logic [7:0]  pri;
        start       = 1'b0;
        command     = speq_pkg::CMD_PUSH;
        prio_req    = '0;
        status_code = '0;
        amount      = '0;
        sys_handle  = '0;
        res_handle  = '0;
        rst_n       = 1'b0;
        idle_on     = 1'b1;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty pop, field extremes, equal priorities, fill to full, full push, pops
        send_pop();
        send_push(8'd0, 4'd0, 16'h8000, 8'd0, 8'd0);
        send_push(8'd255, 4'd15, 16'h7fff, 8'd255, 8'd255);
        send_push(8'd128, 4'd5, 16'hffff, 8'd1, 8'd2);
        send_push(8'd128, 4'd6, 16'h5555, 8'd3, 8'd4);
        send_push(8'd255, 4'd10, 16'haaaa, 8'haa, 8'h55);
        send_push(8'd0, 4'd1, 16'h0001, 8'h55, 8'haa);
        for (int k = 0; k < DEPTH - 6; k++)
            send_push((k % 3 == 0) ? 8'd128 : 8'($urandom), 4'($urandom), 16'($urandom),
                      8'($urandom), 8'($urandom));
        send_push(8'd255, 4'd15, 16'h7fff, 8'd255, 8'd255);
        send_push(8'd0, 4'd0, 16'h8000, 8'd0, 8'd0);
        repeat (5) send_pop();

        // random: alternating fill, drain and balanced stretches
        for (int n = 0; n < N_RANDOM; n++) begin
            idle_on = !(n >= 400 && n < 700);
            case ((n / 120) % 3)
                0:       push_pct = 72;
                1:       push_pct = 28;
                default: push_pct = 50;
            endcase
            if ($urandom_range(0, 99) < push_pct) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: pri = 8'($urandom_range(0, 3) * 85);
                    4:          pri = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                    default:    pri = 8'($urandom);
                endcase
                send_push(pri, 4'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
            end else begin
                send_pop();
            end
        end

        @(negedge clk);
        start <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (25) @(negedge clk);

        $display("Covered %0d items and %0d results, with %0d pushes to a full queue",
                 n_items, n_results, n_full_rejects);
        $display("and %0d pops from an empty queue.", n_empty_pops);
        if (fail_count == 0)
            $display("[sorted_priority_event_queue] OK");
        else
            $display("[sorted_priority_event_queue] ERROR");
        $finish;
    end

endmodule
